>>> src/bbc_pkg.sv
// types, constants and helpers shared by the bracket balance checker
package bbc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int POS_WIDTH   = 16;

    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int COUNT_W = $clog2(STACK_DEPTH + 1);
    localparam int TAB_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 16;
    localparam int OUT_W   = BYTE_W + 2 * FIELD_W;

    localparam logic [BYTE_W-1:0] CH_OPEN_ROUND  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE_ROUND = 8'h29;
    localparam logic [BYTE_W-1:0] CH_OPEN_SQUARE = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_NEWLINE     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB         = 8'h09;

    localparam logic [TAB_W-1:0] TAB_RESET = 4'd4;

    typedef logic [POS_WIDTH-1:0] pos_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [ADDR_W-1:0]    addr_t;

    typedef enum logic [1:0] {
        ST_RUN      = 2'd0,
        ST_BALANCED = 2'd1,
        ST_ERROR    = 2'd2,
        ST_SKIP     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    // one stack entry: kind (1 = square) and position of the opener
    typedef struct packed {
        logic square;
        pos_t line;
        pos_t col;
    } entry_t;

    function automatic pos_t pos_sat_add(pos_t a, pos_t b);
        logic [POS_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_WIDTH] ? {POS_WIDTH{1'b1}} : s[POS_WIDTH-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] opener_char(logic square);
        return square ? CH_OPEN_SQUARE : CH_OPEN_ROUND;
    endfunction

endpackage

>>> src/bracket_balance_checker_core.sv
// bracket nesting checker with line/column tracking and memory-held stack
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata = text_byte, s_tlast = is_last
//  m_       out  m_tvalid/m_tready    m_tuser = status, m_tdata = byte/line/column
//  cfg_     in   cfg_valid/cfg_ready  cfg_data = tab_width
//
// one byte per cycle sustained while m_tready holds; a taken request passes through
// the middle register (with the stack memory read) and then the output register
// the stack memory has one write and two read ports, so a pop with the last
// byte still sees the entry below the popped one
// reset clears counters and flags and restores the tab width; stack memory contents are not cleared
// a stalled m_ side holds the output register and drops s_tready once the
// middle stage is also occupied
module bracket_balance_checker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] bracket_byte, [23:8] error_line, [39:24] error_column
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // [3:0] tab_width
);

    typedef struct packed {
        logic                      skip;
        logic                      err;
        bbc_pkg::op_t              op;
        logic                      square;
        logic [bbc_pkg::BYTE_W-1:0] text;
        bbc_pkg::pos_t             line;
        bbc_pkg::pos_t             col;
        logic                      last;
        logic                      left;
    } mid_t;

    bbc_pkg::entry_t stack_mem [bbc_pkg::STACK_DEPTH];

    bbc_pkg::count_t count_reg, count_next;
    bbc_pkg::pos_t   line_reg, line_next;
    bbc_pkg::pos_t   col_reg, col_next;
    logic            failed_reg, failed_next;
    logic [bbc_pkg::TAB_W-1:0] tab_reg;

    logic            mid_valid_reg;
    mid_t            mid_reg, mid_next;
    bbc_pkg::entry_t rd_a_reg, rd_b_reg;

    logic                      out_valid_reg;
    bbc_pkg::status_t          out_status_reg, res_status;
    logic [bbc_pkg::BYTE_W-1:0] out_byte_reg, res_byte;
    bbc_pkg::pos_t             out_line_reg, res_line;
    bbc_pkg::pos_t             out_col_reg, res_col;

    logic            out_ready, s_acc, mid_adv;
    logic            in_open, in_close, in_square, full, empty, skip_in;
    logic            mismatch, leftover;
    bbc_pkg::pos_t   line_upd, col_upd;
    bbc_pkg::count_t cnt_m1, cnt_m2;
    bbc_pkg::addr_t  wr_addr, rd_a_addr, rd_b_addr;

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !mid_valid_reg || out_ready;
    assign s_acc     = s_tvalid && s_tready;
    assign mid_adv   = mid_valid_reg && out_ready;
    assign cfg_ready = 1'b1;

    assign in_open   = (s_tdata == bbc_pkg::CH_OPEN_ROUND) ||
                       (s_tdata == bbc_pkg::CH_OPEN_SQUARE);
    assign in_close  = (s_tdata == bbc_pkg::CH_CLOSE_ROUND) ||
                       (s_tdata == bbc_pkg::CH_CLOSE_SQUARE);
    assign in_square = (s_tdata == bbc_pkg::CH_OPEN_SQUARE) ||
                       (s_tdata == bbc_pkg::CH_CLOSE_SQUARE);
    assign full      = (count_reg == bbc_pkg::COUNT_W'(bbc_pkg::STACK_DEPTH));
    assign empty     = (count_reg == '0);

    assign cnt_m1    = count_reg - bbc_pkg::COUNT_W'(1);
    assign cnt_m2    = count_reg - bbc_pkg::COUNT_W'(2);
    assign wr_addr   = count_reg[bbc_pkg::ADDR_W-1:0];
    assign rd_a_addr = cnt_m1[bbc_pkg::ADDR_W-1:0];
    assign rd_b_addr = cnt_m2[bbc_pkg::ADDR_W-1:0];

    // middle stage: kind check against the popped entry, leftover check at the end
    assign mismatch = mid_valid_reg && !mid_reg.skip && !mid_reg.err &&
                      (mid_reg.op == bbc_pkg::OP_POP) && (rd_a_reg.square != mid_reg.square);
    assign leftover = !mid_reg.skip && !mid_reg.err && !mismatch &&
                      mid_reg.last && mid_reg.left;

    // a mismatch in the middle stage, unless on the last byte, poisons the request being taken now
    assign skip_in = failed_reg || (mismatch && !mid_reg.last);

    always_comb begin
        res_status = bbc_pkg::ST_RUN;
        res_byte   = '0;
        res_line   = '0;
        res_col    = '0;
        priority if (mid_reg.skip) begin
            res_status = bbc_pkg::ST_SKIP;
        end else if (mid_reg.err) begin
            res_status = bbc_pkg::ST_ERROR;
            res_byte   = mid_reg.text;
            res_line   = mid_reg.line;
            res_col    = mid_reg.col;
        end else if (mismatch) begin
            res_status = bbc_pkg::ST_ERROR;
            res_byte   = bbc_pkg::opener_char(rd_a_reg.square);
            res_line   = rd_a_reg.line;
            res_col    = rd_a_reg.col;
        end else if (leftover) begin
            res_status = bbc_pkg::ST_ERROR;
            unique case (mid_reg.op)
                bbc_pkg::OP_PUSH: begin
                    res_byte = mid_reg.text;
                    res_line = mid_reg.line;
                    res_col  = mid_reg.col;
                end
                bbc_pkg::OP_POP: begin
                    res_byte = bbc_pkg::opener_char(rd_b_reg.square);
                    res_line = rd_b_reg.line;
                    res_col  = rd_b_reg.col;
                end
                default: begin
                    res_byte = bbc_pkg::opener_char(rd_a_reg.square);
                    res_line = rd_a_reg.line;
                    res_col  = rd_a_reg.col;
                end
            endcase
        end else if (mid_reg.last) begin
            res_status = bbc_pkg::ST_BALANCED;
        end else begin
            res_status = bbc_pkg::ST_RUN;
        end
    end

    // position update for the incoming byte
    always_comb begin
        line_upd = line_reg;
        col_upd  = col_reg;
        priority if (s_tdata == bbc_pkg::CH_NEWLINE) begin
            line_upd = (line_reg == {bbc_pkg::POS_WIDTH{1'b1}}) ? line_reg
                     : line_reg + bbc_pkg::POS_WIDTH'(1);
            col_upd  = '0;
        end else if (s_tdata == bbc_pkg::CH_TAB) begin
            col_upd = bbc_pkg::pos_sat_add(col_reg, bbc_pkg::POS_WIDTH'(tab_reg));
        end else begin
            col_upd = bbc_pkg::pos_sat_add(col_reg, bbc_pkg::POS_WIDTH'(1));
        end
    end

    always_comb begin
        count_next  = count_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        failed_next = failed_reg;
        if (mid_adv && mismatch && !mid_reg.last) begin
            failed_next = 1'b1;
        end
        if (s_acc) begin
            if (!skip_in) begin
                line_next = line_upd;
                col_next  = col_upd;
                if (in_open && !full) begin
                    count_next = count_reg + bbc_pkg::COUNT_W'(1);
                end else if (in_close && !empty) begin
                    count_next = cnt_m1;
                end
                if ((in_open && full) || (in_close && empty)) begin
                    failed_next = 1'b1;
                end
            end
            if (s_tlast) begin
                count_next  = '0;
                line_next   = bbc_pkg::POS_WIDTH'(1);
                col_next    = '0;
                failed_next = 1'b0;
            end
        end
    end

    always_comb begin
        mid_next.skip   = skip_in;
        mid_next.err    = (in_open && full) || (in_close && empty);
        mid_next.op     = in_open ? bbc_pkg::OP_PUSH
                        : (in_close ? bbc_pkg::OP_POP : bbc_pkg::OP_NONE);
        mid_next.square = in_square;
        mid_next.text   = s_tdata;
        mid_next.line   = line_upd;
        mid_next.col    = col_upd;
        mid_next.last   = s_tlast;
        // openers still on the stack once this byte is done
        mid_next.left   = in_open ? 1'b1
                        : (in_close ? (count_reg > bbc_pkg::COUNT_W'(1)) : !empty);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            line_reg      <= bbc_pkg::POS_WIDTH'(1);
            col_reg       <= '0;
            failed_reg    <= 1'b0;
            tab_reg       <= bbc_pkg::TAB_RESET;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            failed_reg <= failed_next;
            if (cfg_valid) begin
                tab_reg <= cfg_data;
            end
            if (s_acc) begin
                mid_valid_reg <= 1'b1;
            end else if (mid_adv) begin
                mid_valid_reg <= 1'b0;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            mid_reg <= mid_next;
        end
        if (mid_adv) begin
            out_status_reg <= res_status;
            out_byte_reg   <= res_byte;
            out_line_reg   <= res_line;
            out_col_reg    <= res_col;
        end
    end

    // stack memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (s_acc && !skip_in && in_open && !full) begin
            stack_mem[wr_addr] <= '{square: in_square, line: line_upd, col: col_upd};
        end
        if (s_acc) begin
            rd_a_reg <= stack_mem[rd_a_addr];
            rd_b_reg <= stack_mem[rd_b_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {bbc_pkg::FIELD_W'(out_col_reg), bbc_pkg::FIELD_W'(out_line_reg),
                       out_byte_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bbc_pkg::COUNT_W'(bbc_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tlast) |=> (count_reg == '0 && !failed_reg &&
                                line_reg == bbc_pkg::POS_WIDTH'(1) && col_reg == '0))
        else $error("state not cleared after last byte");

    a_failed_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && failed_reg) |=> mid_reg.skip)
        else $error("byte after error not skipped");

    a_error_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == bbc_pkg::ST_ERROR) |->
            (m_tdata[7:0] == bbc_pkg::CH_OPEN_ROUND || m_tdata[7:0] == bbc_pkg::CH_OPEN_SQUARE ||
             m_tdata[7:0] == bbc_pkg::CH_CLOSE_ROUND ||
             m_tdata[7:0] == bbc_pkg::CH_CLOSE_SQUARE))
        else $error("error result without a bracket");

endmodule
